[rtl/tlfs_pkg.sv]
// ----------------------------------------------------------------------------
// tlfs_pkg: shared types and constants of the three-level feedback scheduler
// Holds the action and register codes, the fixed field widths and the reset
// quantum values used by the scheduler core.
// ----------------------------------------------------------------------------
package tlfs_pkg;

	// number of feedback levels, level 0 has the highest priority
	localparam int NLEVELS = 3;
	localparam int LVL_W   = 2;

	// fixed field widths
	localparam int PROC_W  = 2;
	localparam int BURST_W = 8;
	localparam int QUANT_W = 8;

	// packed stream widths (whole bytes)
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 8;

	typedef logic [LVL_W-1:0]   level_t;
	typedef logic [BURST_W-1:0] work_t;
	typedef logic [QUANT_W-1:0] quant_t;

	// item kind carried in tuser on the input side
	localparam logic ACT_TICK   = 1'b0;
	localparam logic ACT_ARRIVE = 1'b1;

	// configuration register indexes
	localparam logic CFG_QUANTUM_ONE = 1'b0;
	localparam logic CFG_QUANTUM_TWO = 1'b1;

	// register reset values
	localparam quant_t QUANTUM_ONE_RST = 8'd3;
	localparam quant_t QUANTUM_TWO_RST = 8'd6;

	// level codes
	localparam level_t LEVEL_ONE   = 2'd0;
	localparam level_t LEVEL_TWO   = 2'd1;
	localparam level_t LEVEL_THREE = 2'd2;

	localparam work_t WORK_MAX = 8'hFF;

endpackage

[rtl/three_level_feedback_scheduler_core.sv]
// ----------------------------------------------------------------------------
// three_level_feedback_scheduler_core: three-level feedback queue scheduler
// An accepted item is held in the input register; a tick is processed once the result
// register is free and its result shows on m_axis_tvalid. Throughput: one item per cycle
// unless a tick waits on m_axis_tready; the single pass over the queue state sets it.
// arst_n clears queues, work and slice counters and restores both quanta.
// Arrival items give no result; each tick item gives exactly one result.
// ----------------------------------------------------------------------------
module three_level_feedback_scheduler_core #(
	parameter int NPROC = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_wr_en,
	input  logic                            cfg_addr,
	input  logic [tlfs_pkg::QUANT_W-1:0]    cfg_wdata,
	// input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [tlfs_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // arrive_proc[1:0], arrive_burst[9:2]
	input  logic                            s_axis_tuser,  // action
	// result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [tlfs_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // run_proc[1:0], run_level[3:2],
	                                                       // proc_finished[4]
	output logic                            m_axis_tuser   // cpu_busy
);
	import tlfs_pkg::*;

	localparam int ID_W  = $clog2(NPROC);
	localparam int CNT_W = $clog2(NPROC + 1);
	localparam int POS_W = ID_W + 1;

	// configuration registers
	quant_t quantum_one_q, quantum_two_q;

	// input register
	logic                 valid_s1;
	logic                 action_s1;
	logic [PROC_W-1:0]    proc_s1;
	work_t                burst_s1;

	// scheduler state
	work_t            rem_q   [NPROC];
	work_t            slice_q [NPROC];
	logic [ID_W-1:0]  ids_q   [NLEVELS][NPROC];
	logic [ID_W-1:0]  head_q  [NLEVELS];
	logic [CNT_W-1:0] count_q [NLEVELS];

	work_t            rem_n   [NPROC];
	work_t            slice_n [NPROC];
	logic [ID_W-1:0]  ids_n   [NLEVELS][NPROC];
	logic [ID_W-1:0]  head_n  [NLEVELS];
	logic [CNT_W-1:0] count_n [NLEVELS];

	// result register
	logic        out_valid_q;
	logic        busy_q;
	logic [PROC_W-1:0] run_proc_q;
	level_t      run_level_q;
	logic        finished_q;

	// pass control
	logic out_free, advance, do_tick;

	// tick results
	logic             busy_c, finished_c;
	level_t           lvl_c;
	logic [ID_W-1:0]  id_c;

	// tail slot of a circular queue
	function automatic logic [ID_W-1:0] tail_pos(input logic [ID_W-1:0] head,
		input logic [CNT_W-1:0] cnt);
		logic [POS_W-1:0] s;
		s = {1'b0, head} + POS_W'(cnt);
		if (s >= POS_W'(NPROC))
			s = s - POS_W'(NPROC);
		return s[ID_W-1:0];
	endfunction

	// head slot after a pop
	function automatic logic [ID_W-1:0] next_head(input logic [ID_W-1:0] head);
		logic [ID_W-1:0] h;
		if (head == ID_W'(NPROC - 1))
			h = '0;
		else
			h = head + 1'b1;
		return h;
	endfunction

	// handshake: output register frees when empty or taken
	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && ((action_s1 == ACT_ARRIVE) || out_free);
	assign do_tick       = advance && (action_s1 == ACT_TICK);
	assign s_axis_tready = !valid_s1 || advance;

	// next state of the queues and counters
	always_comb begin
		logic [ID_W-1:0] pid;
		logic            arr_ok;
		logic [ID_W-1:0] pos;
		work_t           rem_dec, slice_inc;
		quant_t          quantum;
		logic [LVL_W-1:0] nxt;

		rem_n   = rem_q;
		slice_n = slice_q;
		ids_n   = ids_q;
		head_n  = head_q;
		count_n = count_q;
		busy_c     = 1'b0;
		finished_c = 1'b0;
		lvl_c      = LEVEL_ONE;
		id_c       = '0;
		pid        = ID_W'(proc_s1);
		arr_ok     = 1'b0;
		pos        = '0;
		rem_dec    = '0;
		slice_inc  = '0;
		quantum    = quantum_one_q;
		nxt        = LEVEL_TWO;

		// highest non-empty level
		if (count_q[LEVEL_ONE] != '0) begin
			busy_c = 1'b1;
			lvl_c  = LEVEL_ONE;
		end else if (count_q[LEVEL_TWO] != '0) begin
			busy_c = 1'b1;
			lvl_c  = LEVEL_TWO;
		end else if (count_q[LEVEL_THREE] != '0) begin
			busy_c = 1'b1;
			lvl_c  = LEVEL_THREE;
		end
		id_c = ids_q[lvl_c][head_q[lvl_c]];

		if (advance && action_s1 == ACT_ARRIVE) begin
			// arrival: store burst, append to level one
			arr_ok = (32'(proc_s1) < NPROC) && (burst_s1 != '0);
			if (arr_ok && rem_q[pid] == '0) begin
				rem_n[pid]   = burst_s1;
				slice_n[pid] = '0;
				if (count_q[LEVEL_ONE] < CNT_W'(NPROC)) begin
					pos = tail_pos(head_q[LEVEL_ONE], count_q[LEVEL_ONE]);
					ids_n[LEVEL_ONE][pos] = pid;
					count_n[LEVEL_ONE]    = count_q[LEVEL_ONE] + 1'b1;
				end
			end
		end else if (do_tick && busy_c) begin
			// tick: run the head for one unit
			rem_dec   = (rem_q[id_c] != '0) ? rem_q[id_c] - 1'b1 : rem_q[id_c];
			slice_inc = (lvl_c != LEVEL_THREE && slice_q[id_c] != WORK_MAX) ?
				slice_q[id_c] + 1'b1 : slice_q[id_c];
			quantum   = (lvl_c == LEVEL_ONE) ? quantum_one_q : quantum_two_q;
			nxt       = lvl_c + 1'b1;
			rem_n[id_c]   = rem_dec;
			slice_n[id_c] = slice_inc;
			if (rem_dec == '0) begin
				finished_c      = 1'b1;
				slice_n[id_c]   = '0;
				head_n[lvl_c]   = next_head(head_q[lvl_c]);
				count_n[lvl_c]  = count_q[lvl_c] - 1'b1;
			end else if (lvl_c != LEVEL_THREE && slice_inc >= quantum) begin
				// demote to the tail of the next level
				slice_n[id_c]  = '0;
				head_n[lvl_c]  = next_head(head_q[lvl_c]);
				count_n[lvl_c] = count_q[lvl_c] - 1'b1;
				if (count_q[nxt] < CNT_W'(NPROC)) begin
					pos = tail_pos(head_q[nxt], count_q[nxt]);
					ids_n[nxt][pos] = id_c;
					count_n[nxt]    = count_q[nxt] + 1'b1;
				end
			end
		end
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_one_q <= QUANTUM_ONE_RST;
			quantum_two_q <= QUANTUM_TWO_RST;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			for (int i = 0; i < NPROC; i++) begin
				rem_q[i]   <= '0;
				slice_q[i] <= '0;
			end
			for (int l = 0; l < NLEVELS; l++) begin
				head_q[l]  <= '0;
				count_q[l] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				if (cfg_addr == CFG_QUANTUM_ONE)
					quantum_one_q <= cfg_wdata;
				else
					quantum_two_q <= cfg_wdata;
			end
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (do_tick)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			rem_q   <= rem_n;
			slice_q <= slice_n;
			head_q  <= head_n;
			count_q <= count_n;
		end
	end

	// payload: input register, queue slots, result register
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			action_s1 <= s_axis_tuser;
			proc_s1   <= s_axis_tdata[PROC_W-1:0];
			burst_s1  <= s_axis_tdata[PROC_W+BURST_W-1:PROC_W];
		end
		ids_q <= ids_n;
		if (do_tick) begin
			busy_q      <= busy_c;
			run_proc_q  <= busy_c ? PROC_W'(id_c) : '0;
			run_level_q <= busy_c ? lvl_c : LEVEL_ONE;
			finished_q  <= finished_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = busy_q;
	assign m_axis_tdata  = {3'b000, finished_q, run_level_q, run_proc_q};

endmodule
